### hdl/biquad_lowpass_with_fraction_feedback_assert.svh
// Assertion macros shared by the checker of the biquad low-pass block.
`ifndef BIQUAD_LOWPASS_WITH_FRACTION_FEEDBACK_ASSERT_SVH
`define BIQUAD_LOWPASS_WITH_FRACTION_FEEDBACK_ASSERT_SVH

// Checked on every clock edge outside of reset.
`define BQLP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define BQLP_ASSERT_ALL(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### hdl/bqlp_pkg.sv
// Package: shared constants and types of the biquad low-pass block.
`timescale 1ns / 1ps

package bqlp_pkg;

  localparam int SAMPLE_W  = 16;
  localparam int FRAC_W    = 11;
  localparam int FRAC_LSB  = 4;
  localparam int INT_SHIFT = 15;
  localparam int OUT_MAX   = 32767;
  localparam int NUM_COEFS = 5;
  localparam int CFG_IDX_W = 3;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // Coefficient register indexes
  localparam cfg_idx_t REG_B0 = 3'd0;
  localparam cfg_idx_t REG_B1 = 3'd1;
  localparam cfg_idx_t REG_B2 = 3'd2;
  localparam cfg_idx_t REG_A1 = 3'd3;
  localparam cfg_idx_t REG_A2 = 3'd4;

  // Filter history handed from the state registers to the datapath
  typedef struct packed {
    logic signed [SAMPLE_W-1:0] x_prev1;
    logic signed [SAMPLE_W-1:0] x_prev2;
    logic signed [SAMPLE_W-1:0] y_prev1;
    logic signed [SAMPLE_W-1:0] y_prev2_neg;
    logic        [FRAC_W-1:0]   frac_prev1;
    logic signed [FRAC_W:0]     frac_prev2_neg;
  } hist_t;

endpackage

### hdl/bqlp_datapath.sv
// Combinational biquad arithmetic: fraction feedback, five taps, clip.
`timescale 1ns / 1ps

module bqlp_datapath #(
  parameter int COEF_WIDTH = 18
) (
  input  logic signed [bqlp_pkg::SAMPLE_W-1:0] sample,
  input  bqlp_pkg::hist_t                      hist,
  input  logic signed [COEF_WIDTH-1:0]         coef_b0,
  input  logic signed [COEF_WIDTH-1:0]         coef_b1,
  input  logic signed [COEF_WIDTH-1:0]         coef_b2,
  input  logic signed [COEF_WIDTH-1:0]         coef_a1,
  input  logic signed [COEF_WIDTH-1:0]         coef_a2,
  output logic signed [bqlp_pkg::SAMPLE_W-1:0] y,
  output logic        [bqlp_pkg::FRAC_W-1:0]   frac
);

  localparam int SW     = bqlp_pkg::SAMPLE_W;
  localparam int FW     = bqlp_pkg::FRAC_W;
  localparam int TAP_W  = COEF_WIDTH + SW;
  localparam int FP_W   = COEF_WIDTH + FW + 1;
  localparam int FS_W   = FP_W + 1;
  localparam int FSH_W  = FS_W - FW;
  localparam int ACC_W  = COEF_WIDTH + SW + 3;
  localparam int HI_W   = ACC_W - bqlp_pkg::INT_SHIFT;
  localparam logic signed [HI_W-1:0] HI_MAX = HI_W'(bqlp_pkg::OUT_MAX);
  localparam logic signed [HI_W-1:0] HI_MIN = -HI_MAX;

  logic signed [FW:0]        f1_s;
  logic signed [FP_W-1:0]    pf1;
  logic signed [FP_W-1:0]    pf2;
  logic signed [FS_W-1:0]    fsum;
  logic signed [FSH_W-1:0]   fshift;
  logic signed [TAP_W-1:0]   p_b0;
  logic signed [TAP_W-1:0]   p_b1;
  logic signed [TAP_W-1:0]   p_b2;
  logic signed [TAP_W-1:0]   p_a1;
  logic signed [TAP_W-1:0]   p_a2;
  logic signed [ACC_W-1:0]   acc;
  logic signed [HI_W-1:0]    hi;

  // error feedback: stored fractions through the feedback coefficients
  assign f1_s   = $signed({1'b0, hist.frac_prev1});
  assign pf1    = f1_s * coef_a1;
  assign pf2    = hist.frac_prev2_neg * coef_a2;
  assign fsum   = FS_W'(pf1) + FS_W'(pf2);
  assign fshift = fsum[FS_W-1:FW];  // floor shift by the fraction width

  assign p_b0 = sample * coef_b0;
  assign p_b1 = hist.x_prev1 * coef_b1;
  assign p_b2 = hist.x_prev2 * coef_b2;
  assign p_a1 = hist.y_prev1 * coef_a1;
  assign p_a2 = hist.y_prev2_neg * coef_a2;

  assign acc = ACC_W'(fshift) + ACC_W'(p_b0) + ACC_W'(p_b1) + ACC_W'(p_b2)
             + ACC_W'(p_a1) + ACC_W'(p_a2);

  assign hi = acc[ACC_W-1:bqlp_pkg::INT_SHIFT];

  always_comb begin
    if (hi > HI_MAX) begin
      y    = SW'(HI_MAX);
      frac = '0;
    end else if (hi < HI_MIN) begin
      y    = SW'(HI_MIN);
      frac = '0;
    end else begin
      y    = hi[SW-1:0];
      frac = acc[bqlp_pkg::INT_SHIFT-1:bqlp_pkg::FRAC_LSB];
    end
  end

endmodule

### hdl/biquad_lowpass_with_fraction_feedback.sv
// Top level: second-order IIR low-pass filter with output-fraction error feedback.
`timescale 1ns / 1ps

// Biquad low-pass on signed 16-bit samples with Q15 coefficients of
// COEF_WIDTH bits. Each transfer carries one sample and a reset_n flag; a
// transfer with reset_n low clears the filter history (coefficients stay)
// and yields a zero result, otherwise the sample is filtered and one result
// is produced: the output integer part, clipped to +-32767, and the 11-bit
// output fraction, which is fed back into the next two samples and is zero
// whenever the output clips. Throughput is one sample per clock while the
// output is not stalled; an item goes from the input register to the result
// register, where it is shown as valid. The rate is set by the recursion:
// the five tap multiplies, the fraction feedback term, the accumulate and
// the clip are all combinational between the input register and the result
// register, and the history registers update in the same edge the result
// is registered. in_stall rises only while the result register holds an
// unaccepted result and the input register is full. Coefficients are
// written through the cfg port at indexes b0, b1, b2, a1, a2 (0 to 4); the
// user must write them only while the filter is idle, which the block does
// not enforce; other indexes are ignored. All coefficients reset to zero.
module biquad_lowpass_with_fraction_feedback #(
  parameter int COEF_WIDTH = 18
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // input channel
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_reset_n,
  input  logic signed [bqlp_pkg::SAMPLE_W-1:0] in_sample_in,
  // result channel
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic signed [bqlp_pkg::SAMPLE_W-1:0] out_sample_out,
  output logic        [bqlp_pkg::FRAC_W-1:0]   out_frac_out,
  // coefficient write port
  input  logic                                 cfg_we,
  input  bqlp_pkg::cfg_idx_t                   cfg_index,
  input  logic        [COEF_WIDTH-1:0]         cfg_data
);

  localparam int SW = bqlp_pkg::SAMPLE_W;
  localparam int FW = bqlp_pkg::FRAC_W;

  // coefficients
  logic signed [COEF_WIDTH-1:0] coef_b0_r;
  logic signed [COEF_WIDTH-1:0] coef_b1_r;
  logic signed [COEF_WIDTH-1:0] coef_b2_r;
  logic signed [COEF_WIDTH-1:0] coef_a1_r;
  logic signed [COEF_WIDTH-1:0] coef_a2_r;

  // input register
  logic                 s1_valid_r;
  logic                 s1_valid_nxt;
  logic                 s1_run_r;    // copy of reset_n: high means filter
  logic signed [SW-1:0] s1_sample_r;

  // result register
  logic                 out_valid_r;
  logic                 out_valid_nxt;
  logic signed [SW-1:0] out_sample_r;
  logic        [FW-1:0] out_frac_r;

  // filter history
  bqlp_pkg::hist_t      hist_r;
  bqlp_pkg::hist_t      hist_nxt;

  logic                 in_xfer;
  logic                 res_free;    // result register can load this cycle
  logic                 s1_move;     // input register item moves to result
  logic signed [SW-1:0] dp_y;
  logic        [FW-1:0] dp_frac;
  logic signed [SW-1:0] res_y;
  logic        [FW-1:0] res_frac;

  assign res_free      = !out_valid_r || !out_stall;
  assign s1_move       = s1_valid_r && res_free;
  assign in_stall      = s1_valid_r && !res_free;
  assign in_xfer       = in_valid && !in_stall;
  assign s1_valid_nxt  = in_xfer || (s1_valid_r && !res_free);
  assign out_valid_nxt = s1_move || (out_valid_r && out_stall);

  bqlp_datapath #(
    .COEF_WIDTH (COEF_WIDTH)
  ) u_dp (
    .sample  (s1_sample_r),
    .hist    (hist_r),
    .coef_b0 (coef_b0_r),
    .coef_b1 (coef_b1_r),
    .coef_b2 (coef_b2_r),
    .coef_a1 (coef_a1_r),
    .coef_a2 (coef_a2_r),
    .y       (dp_y),
    .frac    (dp_frac)
  );

  // a clear request yields zeros and wipes the history
  assign res_y    = s1_run_r ? dp_y : '0;
  assign res_frac = s1_run_r ? dp_frac : '0;

  always_comb begin
    hist_nxt = hist_r;
    if (s1_move) begin
      if (!s1_run_r) begin
        hist_nxt = '0;
      end else begin
        hist_nxt.x_prev2        = hist_r.x_prev1;
        hist_nxt.x_prev1        = s1_sample_r;
        hist_nxt.y_prev2_neg    = -hist_r.y_prev1;
        hist_nxt.y_prev1        = dp_y;
        hist_nxt.frac_prev2_neg = -$signed({1'b0, hist_r.frac_prev1});
        hist_nxt.frac_prev1     = dp_frac;
      end
    end
  end

  // control, history and coefficients
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      hist_r      <= '0;
      coef_b0_r   <= '0;
      coef_b1_r   <= '0;
      coef_b2_r   <= '0;
      coef_a1_r   <= '0;
      coef_a2_r   <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      hist_r      <= hist_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          bqlp_pkg::REG_B0: coef_b0_r <= $signed(cfg_data);
          bqlp_pkg::REG_B1: coef_b1_r <= $signed(cfg_data);
          bqlp_pkg::REG_B2: coef_b2_r <= $signed(cfg_data);
          bqlp_pkg::REG_A1: coef_a1_r <= $signed(cfg_data);
          bqlp_pkg::REG_A2: coef_a2_r <= $signed(cfg_data);
          default: ;
        endcase
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_run_r    <= in_reset_n;
      s1_sample_r <= in_sample_in;
    end
    if (s1_move) begin
      out_sample_r <= res_y;
      out_frac_r   <= res_frac;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;
  assign out_frac_out   = out_frac_r;

endmodule

### hdl/bqlp_checker.sv
// Port-level assertion checker for the biquad low-pass block, with its bind.
`timescale 1ns / 1ps
`include "biquad_lowpass_with_fraction_feedback_assert.svh"

module bqlp_checker (
  input logic                                 clk,
  input logic                                 rst_n,
  input logic                                 in_valid,
  input logic                                 in_stall,
  input logic                                 out_valid,
  input logic                                 out_stall,
  input logic signed [bqlp_pkg::SAMPLE_W-1:0] out_sample_out,
  input logic        [bqlp_pkg::FRAC_W-1:0]   out_frac_out
);

  // held result stays put while stalled
  `BQLP_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_sample_out) && $stable(out_frac_out), "stalled result changed")

  // input backs up only behind a blocked result
  `BQLP_ASSERT(a_stall_cause, in_stall |-> out_valid && out_stall, "input stalled without blocked output")

  // a fresh result traces back to an input transfer through the input register
  `BQLP_ASSERT(a_out_origin, $rose(out_valid) |-> $past(in_valid && !in_stall, 2), "result without matching input transfer")

  // clipping is symmetric: the most negative code never appears
  `BQLP_ASSERT_ALL(a_out_range, out_valid && rst_n |-> out_sample_out != 16'sh8000, "output outside +-32767")

endmodule

bind biquad_lowpass_with_fraction_feedback bqlp_checker u_bqlp_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_sample_out (out_sample_out),
  .out_frac_out   (out_frac_out)
);

### bench/testbench.sv
// Self-checking testbench of the biquad low-pass filter with fraction feedback.
`timescale 1ns / 1ps

module testbench;

  localparam int SAMPLE_W  = bqlp_pkg::SAMPLE_W;
  localparam int FRAC_W    = bqlp_pkg::FRAC_W;
  localparam int FRAC_LSB  = bqlp_pkg::FRAC_LSB;
  localparam int INT_SHIFT = bqlp_pkg::INT_SHIFT;
  localparam int OUT_MAX   = bqlp_pkg::OUT_MAX;
  localparam int NUM_COEFS = bqlp_pkg::NUM_COEFS;
  localparam int CFG_IDX_W = bqlp_pkg::CFG_IDX_W;

  typedef bqlp_pkg::cfg_idx_t cfg_idx_t;

  localparam cfg_idx_t REG_B0 = bqlp_pkg::REG_B0;
  localparam cfg_idx_t REG_B1 = bqlp_pkg::REG_B1;
  localparam cfg_idx_t REG_B2 = bqlp_pkg::REG_B2;
  localparam cfg_idx_t REG_A1 = bqlp_pkg::REG_A1;
  localparam cfg_idx_t REG_A2 = bqlp_pkg::REG_A2;

  localparam int COEF_W      = 18;
  localparam int LONG_HOLD   = 40;      // output hold-off, long enough to fill the pipe
  localparam int N_PHASES    = 7;
  localparam int PHASE_ITEMS = 250;
  localparam int WATCHDOG_NS = 1_000_000;

  // Coefficient extremes at the register width
  localparam logic [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
  localparam logic [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};

  // A well-behaved low-pass: DC gain of about 2.3, poles inside the unit circle
  localparam logic [COEF_W-1:0] LP_B0 = 1500;
  localparam logic [COEF_W-1:0] LP_B1 = 3000;
  localparam logic [COEF_W-1:0] LP_A1 = 52429;
  localparam logic [COEF_W-1:0] LP_A2 = 22282;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] y;
    logic        [FRAC_W-1:0]   f;
  } result_t;

  typedef enum logic {ROW_SAMPLE, ROW_COEF} row_kind_t;

  // One line of the directed script: either a sample transfer (with an
  // optional typed-in result) or a coefficient write.
  typedef struct packed {
    row_kind_t                  kind;
    logic                       rn;
    logic signed [SAMPLE_W-1:0] smp;
    cfg_idx_t                   idx;
    logic        [COEF_W-1:0]   data;
    logic                       known;
    logic signed [SAMPLE_W-1:0] y;
    logic        [FRAC_W-1:0]   f;
  } script_row_t;

  logic                       clk;
  logic                       rst_n;
  logic                       in_valid;
  logic                       in_stall;
  logic                       in_reset_n;
  logic signed [SAMPLE_W-1:0] in_sample_in;
  logic                       out_valid;
  logic                       out_stall;
  logic signed [SAMPLE_W-1:0] out_sample_out;
  logic        [FRAC_W-1:0]   out_frac_out;
  logic                       cfg_we;
  cfg_idx_t                   cfg_index;
  logic        [COEF_W-1:0]   cfg_data;

  biquad_lowpass_with_fraction_feedback #(
    .COEF_WIDTH(COEF_W)
  ) dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_reset_n    (in_reset_n),
    .in_sample_in  (in_sample_in),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_sample_out(out_sample_out),
    .out_frac_out  (out_frac_out),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // ---------------------------------------------------------------------
  // Filter model: coefficient copy, history and one step per transfer
  // ---------------------------------------------------------------------
  logic signed [COEF_W-1:0]   coef_b0, coef_b1, coef_b2, coef_a1, coef_a2;
  logic signed [SAMPLE_W-1:0] hist_x1, hist_x2, hist_y1, hist_y2_neg;
  logic        [FRAC_W-1:0]   hist_f1;
  logic signed [FRAC_W:0]     hist_f2_neg;

  result_t expected_outputs[$];

  int errors      = 0;
  int n_sent      = 0;
  int n_clears    = 0;
  int n_clips     = 0;
  int n_results   = 0;
  int n_coef_sets = 0;

  // Shared knobs between the sender and the receiver
  bit idle_on       = 1'b1;
  int send_gap_pct  = 20;
  int stall_pct     = 20;
  int hold_asked    = 0;

  function automatic void clear_history();
    hist_x1     = '0;
    hist_x2     = '0;
    hist_y1     = '0;
    hist_y2_neg = '0;
    hist_f1     = '0;
    hist_f2_neg = '0;
  endfunction

  function automatic result_t filter_step(logic rn, logic signed [SAMPLE_W-1:0] x);
    longint  acc;
    longint  hi;
    result_t r;
    if (!rn) begin
      // clear request: history wiped, coefficients kept, zero result
      clear_history();
      n_clears++;
      r = '0;
      return r;
    end
    // fraction feedback first, floored down to integer weight
    acc = longint'(hist_f1) * longint'(coef_a1) + longint'(hist_f2_neg) * longint'(coef_a2);
    acc = acc >>> FRAC_W;
    acc += longint'(x) * longint'(coef_b0) + longint'(hist_x1) * longint'(coef_b1)
         + longint'(hist_x2) * longint'(coef_b2) + longint'(hist_y1) * longint'(coef_a1)
         + longint'(hist_y2_neg) * longint'(coef_a2);
    r.f = acc[FRAC_LSB +: FRAC_W];
    hi  = acc >>> INT_SHIFT;
    if (hi > OUT_MAX) begin
      r.y = SAMPLE_W'(OUT_MAX);
      r.f = '0;
      n_clips++;
    end else if (hi < -OUT_MAX) begin
      r.y = SAMPLE_W'(-OUT_MAX);
      r.f = '0;
      n_clips++;
    end else begin
      r.y = hi[SAMPLE_W-1:0];
    end
    hist_f2_neg = -$signed({1'b0, hist_f1});
    hist_f1     = r.f;
    hist_x2     = hist_x1;
    hist_x1     = x;
    hist_y2_neg = -hist_y1;
    hist_y1     = r.y;
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // Directed script rows
  // ---------------------------------------------------------------------
  function automatic script_row_t feed(logic rn, logic signed [SAMPLE_W-1:0] s);
    script_row_t row;
    row      = '0;
    row.kind = ROW_SAMPLE;
    row.rn   = rn;
    row.smp  = s;
    return row;
  endfunction

  function automatic script_row_t feed_known(logic rn, logic signed [SAMPLE_W-1:0] s,
                                             logic signed [SAMPLE_W-1:0] y,
                                             logic [FRAC_W-1:0] f);
    script_row_t row;
    row       = feed(rn, s);
    row.known = 1'b1;
    row.y     = y;
    row.f     = f;
    return row;
  endfunction

  function automatic script_row_t coef_row(cfg_idx_t idx, logic [COEF_W-1:0] data);
    script_row_t row;
    row      = '0;
    row.kind = ROW_COEF;
    row.idx  = idx;
    row.data = data;
    return row;
  endfunction

  // ---------------------------------------------------------------------
  // Clock, watchdog
  // ---------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #(WATCHDOG_NS);
    $display("testbench: errors");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Sender-side tasks; all of them start and end on a falling edge
  // ---------------------------------------------------------------------

  // One sample transfer. An optional random gap drops valid first; valid is
  // otherwise left high so back-to-back transfers need no second assignment.
  task automatic push_sample(logic rn, logic signed [SAMPLE_W-1:0] s, logic known,
                             logic signed [SAMPLE_W-1:0] ky, logic [FRAC_W-1:0] kf);
    result_t r;
    if (idle_on && $urandom_range(0, 99) < send_gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_reset_n   <= rn;
    in_sample_in <= s;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // transfer taken at this edge: step the model in acceptance order
    r = filter_step(rn, s);
    if (known) begin
      r.y = ky;
      r.f = kf;
    end
    expected_outputs.push_back(r);
    n_sent++;
    @(negedge clk);
  endtask

  // Stop offering and wait for the last result; coefficient writes follow.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_outputs.size() != 0) @(negedge clk);
  endtask

  // Drives one write for a cycle; the caller lowers cfg_we after a batch.
  task automatic write_coef(cfg_idx_t idx, logic [COEF_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    case (idx)
      REG_B0:  coef_b0 = val;
      REG_B1:  coef_b1 = val;
      REG_B2:  coef_b2 = val;
      REG_A1:  coef_a1 = val;
      REG_A2:  coef_a2 = val;
      default: ;  // unused index, no register behind it
    endcase
    @(negedge clk);
  endtask

  // New coefficient set for a random phase, plus one write to an unused index.
  task automatic load_coefs(int style);
    logic [COEF_W-1:0] c[5];
    int                a2;
    a2 = $urandom_range(4000, 30000);
    for (int i = 0; i < 5; i++) begin
      case (style)
        0:       c[i] = COEF_W'($urandom_range(0, 6000));                // stable low-pass
        1:       c[i] = COEF_W'($urandom);                               // anything goes
        2:       c[i] = $urandom_range(0, 1) ? COEF_MAX : COEF_MIN;      // corners
        default: c[i] = COEF_W'($urandom_range(0, 8191) - 4096);         // small, signed
      endcase
    end
    if (style == 0) begin
      c[3] = COEF_W'($urandom_range(8000, 32768 + a2 - 1000));
      c[4] = COEF_W'(a2);
    end
    write_coef(REG_B0, c[0]);
    write_coef(REG_B1, c[1]);
    write_coef(REG_B2, c[2]);
    write_coef(REG_A1, c[3]);
    write_coef(REG_A2, c[4]);
    write_coef(cfg_idx_t'($urandom_range(NUM_COEFS, (1 << CFG_IDX_W) - 1)),
               COEF_W'($urandom));
    cfg_we <= 1'b0;
    n_coef_sets++;
  endtask

  function automatic logic signed [SAMPLE_W-1:0] pick_sample(logic signed [SAMPLE_W-1:0] prev);
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: return SAMPLE_W'($urandom);
      5:             return SAMPLE_W'($urandom_range(0, 511)) - 16'sd256;
      6:             return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      7, 8:          return prev;  // hold the level: step responses
      default:       return SAMPLE_W'($urandom_range(0, 2)) - 16'sd1;
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Receiver: random stall bursts, free stretches, and on request one long
  // hold-off counted here so the input side backs up.
  // ---------------------------------------------------------------------
  initial begin
    int hold_given;
    hold_given = 0;
    out_stall  = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_given != hold_asked) begin
        hold_given = hold_asked;
        out_stall <= 1'b1;
        repeat (LONG_HOLD - 1) @(negedge clk);
      end else if (idle_on && $urandom_range(0, 99) < stall_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 4) - 1) @(negedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat ($urandom_range(0, 6)) @(negedge clk);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Result checker: every output transfer against the oldest expectation
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    result_t want;
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      if (expected_outputs.size() == 0) begin
        $error("unexpected result: sample_out %0d frac_out %0d", out_sample_out, out_frac_out);
        errors++;
      end else begin
        want = expected_outputs.pop_front();
        if (out_sample_out !== want.y) begin
          $error("sample_out: expected %0d, got %0d", want.y, out_sample_out);
          errors++;
        end
        if (out_frac_out !== want.f) begin
          $error("frac_out: expected %0d, got %0d", want.f, out_frac_out);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------
  initial begin
    script_row_t                script[$];
    logic signed [SAMPLE_W-1:0] prev;
    bit                         writing;

    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_reset_n   = 1'b1;
    in_sample_in = '0;
    cfg_we       = 1'b0;
    cfg_index    = REG_B0;
    cfg_data     = '0;
    coef_b0      = '0;
    coef_b1      = '0;
    coef_b2      = '0;
    coef_a1      = '0;
    coef_a2      = '0;
    clear_history();
    writing      = 1'b0;

    script = '{
      // coefficients still at reset: everything filters to zero
      feed_known(1'b1, 16'sh7fff, 16'sd0, 11'd0),
      feed_known(1'b1, 16'sh8000, 16'sd0, 11'd0),
      feed_known(1'b0, 16'sh1234, 16'sd0, 11'd0),
      // pure gain of almost four: clipping both ways, fraction from one LSB
      coef_row(REG_B0, COEF_MAX),
      coef_row(REG_B1, '0),
      coef_row(REG_B2, '0),
      coef_row(REG_A1, '0),
      coef_row(REG_A2, '0),
      coef_row(cfg_idx_t'(NUM_COEFS), '1),   // unused indexes change nothing
      coef_row('1, COEF_MIN),
      feed_known(1'b1, 16'sh7fff, 16'sd32767, 11'd0),
      feed_known(1'b1, 16'sh8000, -16'sd32767, 11'd0),
      feed_known(1'b1, 16'sd1, 16'sd3, 11'd2047),
      feed_known(1'b1, -16'sd1, -16'sd4, 11'd0),
      feed_known(1'b1, 16'sd0, 16'sd0, 11'd0),
      // real low-pass: step up, step down, clear in the middle of the ringing
      coef_row(REG_B0, LP_B0),
      coef_row(REG_B1, LP_B1),
      coef_row(REG_B2, LP_B0),
      coef_row(REG_A1, LP_A1),
      coef_row(REG_A2, LP_A2),
      feed(1'b1, 16'sh7fff),
      feed(1'b1, 16'sh7fff),
      feed(1'b1, 16'sh7fff),
      feed(1'b1, 16'sh7fff),
      feed(1'b1, 16'sh8000),
      feed(1'b1, 16'sh8000),
      feed(1'b1, 16'sd100),
      feed_known(1'b0, 16'sd0, 16'sd0, 11'd0),
      feed(1'b1, 16'sh8000),
      // every coefficient at its most negative value
      coef_row(REG_B0, COEF_MIN),
      coef_row(REG_B1, COEF_MIN),
      coef_row(REG_B2, COEF_MIN),
      coef_row(REG_A1, COEF_MIN),
      coef_row(REG_A2, COEF_MIN),
      feed(1'b1, 16'sh7fff),
      feed(1'b1, 16'sh8000),
      feed(1'b1, 16'sd1),
      feed(1'b1, -16'sd1),
      // and at its most positive
      coef_row(REG_B0, COEF_MAX),
      coef_row(REG_B1, COEF_MAX),
      coef_row(REG_B2, COEF_MAX),
      coef_row(REG_A1, COEF_MAX),
      coef_row(REG_A2, COEF_MAX),
      feed(1'b1, -16'sd1),
      feed(1'b1, 16'sd1),
      feed(1'b1, 16'sd0),
      feed_known(1'b0, 16'sh8000, 16'sd0, 11'd0)
    };

    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed script. Coefficient rows wait for the pipe to empty first.
    foreach (script[i]) begin
      if (script[i].kind == ROW_COEF) begin
        if (!writing) wait_drained();
        write_coef(script[i].idx, script[i].data);
        writing = 1'b1;
      end else begin
        if (writing) begin
          cfg_we <= 1'b0;
          writing = 1'b0;
          n_coef_sets++;
        end
        push_sample(script[i].rn, script[i].smp, script[i].known, script[i].y, script[i].f);
      end
    end

    // Random phases: each starts from an empty pipe with a fresh coefficient
    // set; one phase carries the long output hold-off, the last has no idling.
    for (int p = 0; p < N_PHASES; p++) begin
      wait_drained();
      load_coefs(p % 4);
      idle_on      = (p != N_PHASES - 1);
      send_gap_pct = $urandom_range(5, 35);
      stall_pct    = $urandom_range(5, 35);
      prev         = '0;
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (p == 2 && k == PHASE_ITEMS / 2) hold_asked++;
        prev = pick_sample(prev);
        push_sample($urandom_range(0, 39) != 0, prev, 1'b0, '0, '0);
      end
    end

    wait_drained();
    repeat (8) @(posedge clk);

    $display("summary: %0d samples in (%0d clear requests), %0d results checked",
             n_sent, n_clears, n_results);
    $display("summary: %0d coefficient sets, %0d clipped outputs, long output hold-off done",
             n_coef_sets, n_clips);
    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

### files.f
+incdir+hdl
hdl/bqlp_pkg.sv
hdl/bqlp_datapath.sv
hdl/biquad_lowpass_with_fraction_feedback.sv
hdl/bqlp_checker.sv
bench/testbench.sv
